// File: hw/rtl/rbss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbss_pkg
// Shared widths, constants and register indexes for the region band
// smoothstep weight engine.
// ----------------------------------------------------------------------------
package rbss_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int VAL_W       = FRAC_BITS + 1;      // Q1.16 values
    localparam int IDX_W       = 3;
    localparam int INV_W       = 32;                 // Q16.16 reciprocal
    localparam int INV_HALF_W  = INV_W / 2;
    localparam int RCNT_W      = 3;
    localparam int NUM_BOUNDS  = 4;
    localparam int BIDX_W      = 2;
    localparam int MAX_REGIONS = 5;
    localparam int MIN_REGIONS = 2;

    localparam int K_W    = VAL_W + 1;               // 3*ONE - 2x
    localparam int PP_W   = VAL_W + INV_HALF_W;      // diff * half of reciprocal
    localparam int XR_W   = PP_W + 1;
    localparam int SQ_W   = 2 * VAL_W;
    localparam int PROD_W = VAL_W + K_W;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 40;
    localparam int OUT_IDX_LSB = 0;
    localparam int OUT_RW_LSB  = OUT_IDX_LSB + IDX_W;
    localparam int OUT_PW_LSB  = OUT_RW_LSB + VAL_W;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_PW_LSB - VAL_W;

    typedef logic [VAL_W-1:0] val_t;
    typedef logic [IDX_W-1:0] idx_t;

    localparam val_t ONE  = val_t'(1) << FRAC_BITS;
    localparam val_t HALF = val_t'(1) << (FRAC_BITS - 1);
    localparam logic [K_W-1:0] THREE_ONE = K_W'(3) << FRAC_BITS;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_WIDTH = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_WIDTH   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_CNT  = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_0     = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_1     = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_2     = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_3     = 8'd7;

    localparam logic [RCNT_W-1:0] RCNT_RESET = 3'd3;
    localparam val_t BOUND_0_RESET = 17'd21845;
    localparam val_t BOUND_1_RESET = 17'd43691;
    localparam val_t BOUND_2_RESET = 17'd65536;
    localparam val_t BOUND_3_RESET = 17'd65536;

endpackage

// File: hw/rtl/region_band_smoothstep_weights.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_band_smoothstep_weights
// Finds the region of a Q1.16 position and, inside the blend band above the
// lower boundary, splits weight between it and the previous region with a
// smoothstep curve.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  s_      | in        | s_tvalid / s_tready | tdata: position
//  m_      | out       | m_tvalid / m_tready | tdata: index, weights; tuser: blending
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One position per cycle sustained while the output is not stalled.
//  Eight register stages: search, band check, split reciprocal multiply,
//  round/clamp, square, round, cubic multiply, output register.
//  Reset clears the stage valid bits and loads the register defaults.
//  Each stage moves whenever the stage after it is empty or moving, so a
//  stalled output still lets requests fill the bubbles behind it.
//  cfg_ready is always high.
module region_band_smoothstep_weights
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rbss_pkg::IN_DATA_W-1:0]    s_tdata,   // [16:0] position
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rbss_pkg::OUT_DATA_W-1:0]   m_tdata,   // [2:0] region_index,
                                                         // [19:3] region_weight,
                                                         // [36:20] previous_weight
    output logic                              m_tuser,   // [0] blending
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rbss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rbss_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rbss_pkg::*;

    localparam int NUM_STAGES = 8;

    // configuration
    logic                   blend_mode_reg;
    val_t                   trans_width_reg;
    logic [INV_W-1:0]       inv_width_reg;
    logic [RCNT_W-1:0]      region_cnt_reg;
    val_t                   bound_reg [NUM_BOUNDS];

    // pipeline control
    logic [NUM_STAGES-1:0]  valid_reg;
    logic [NUM_STAGES-1:0]  valid_next;
    logic [NUM_STAGES-1:0]  adv;

    // index rides along with each stage, the blend flag with each stage from stage 1 on
    idx_t                   idx_reg   [NUM_STAGES];
    idx_t                   idx_next;
    logic                   blend_reg [1:NUM_STAGES-1];
    logic                   blend_next;

    // payload per stage
    val_t                   pos_reg, pos_next;
    val_t                   diff_reg, diff_next;
    logic [PP_W-1:0]        plo_reg, plo_next;
    logic [PP_W-1:0]        phi_reg, phi_next;
    val_t                   x_reg, x_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic [K_W-1:0]         k_reg, k_next;
    val_t                   x2_reg, x2_next;
    logic [K_W-1:0]         k2_reg, k2_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    val_t                   rw_reg, rw_next;
    val_t                   pw_reg, pw_next;

    // stage-local combinational values
    logic [RCNT_W-1:0]      n_eff;
    logic                   found;
    logic [BIDX_W-1:0]      bsel;
    idx_t                   idx_m1;
    val_t                   bnd;
    logic [VAL_W:0]         band_top;
    logic [XR_W-1:0]        lo_rnd;
    logic [XR_W-1:0]        x_raw;
    logic [SQ_W-1:0]        sq_rnd;
    logic [PROD_W-1:0]      w_rnd;
    logic [PROD_W-FRAC_BITS-1:0] w_sh;
    val_t                   w_val;

    //--------------------------------------------------------------------
    // config port
    //--------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg  <= 1'b0;
            trans_width_reg <= '0;
            inv_width_reg   <= '0;
            region_cnt_reg  <= RCNT_RESET;
            bound_reg[0]    <= BOUND_0_RESET;
            bound_reg[1]    <= BOUND_1_RESET;
            bound_reg[2]    <= BOUND_2_RESET;
            bound_reg[3]    <= BOUND_3_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BLEND_MODE:  blend_mode_reg  <= cfg_data[0];
                REG_TRANS_WIDTH: trans_width_reg <= cfg_data[VAL_W-1:0];
                REG_INV_WIDTH:   inv_width_reg   <= cfg_data[INV_W-1:0];
                REG_REGION_CNT:  region_cnt_reg  <= cfg_data[RCNT_W-1:0];
                REG_BOUND_0:     bound_reg[0]    <= cfg_data[VAL_W-1:0];
                REG_BOUND_1:     bound_reg[1]    <= cfg_data[VAL_W-1:0];
                REG_BOUND_2:     bound_reg[2]    <= cfg_data[VAL_W-1:0];
                REG_BOUND_3:     bound_reg[3]    <= cfg_data[VAL_W-1:0];
                default:         ;
            endcase
        end
    end

    //--------------------------------------------------------------------
    // stage advance: a stage moves when it is empty or the next one moves
    //--------------------------------------------------------------------
    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next[0] = s_tvalid;
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = valid_reg[k-1];
        end
    end

    assign s_tready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= (valid_next & adv) | (valid_reg & ~adv);
        end
    end

    //--------------------------------------------------------------------
    // stage 0: region search
    //--------------------------------------------------------------------
    always_comb
    begin
        pos_next = s_tdata[VAL_W-1:0];
        if (region_cnt_reg < RCNT_W'(MIN_REGIONS))
            n_eff = RCNT_W'(MIN_REGIONS);
        else if (region_cnt_reg > RCNT_W'(MAX_REGIONS))
            n_eff = RCNT_W'(MAX_REGIONS);
        else
            n_eff = region_cnt_reg;

        // first boundary at or above the position; last region catches the rest
        idx_next = IDX_W'(n_eff - RCNT_W'(1));
        found    = 1'b0;
        for (int i = 0; i < NUM_BOUNDS; i++)
        begin
            if (!found && (RCNT_W'(i + 1) < n_eff) && (pos_next <= bound_reg[i]))
            begin
                idx_next = IDX_W'(i);
                found    = 1'b1;
            end
        end
    end

    //--------------------------------------------------------------------
    // stage 1: lower boundary, offset into band, band check
    //--------------------------------------------------------------------
    always_comb
    begin
        idx_m1     = idx_reg[0] - IDX_W'(1);
        bsel       = idx_m1[BIDX_W-1:0];
        bnd        = bound_reg[bsel];
        band_top   = {1'b0, bnd} + {1'b0, trans_width_reg};
        diff_next  = pos_reg - bnd;
        blend_next = blend_mode_reg && (trans_width_reg != '0) &&
                     (idx_reg[0] != '0) && ({1'b0, pos_reg} < band_top);
    end

    //--------------------------------------------------------------------
    // stage 2: diff * inverse_width, split into two 16-bit halves
    //--------------------------------------------------------------------
    always_comb
    begin
        plo_next = PP_W'(diff_reg) * PP_W'(inv_width_reg[INV_HALF_W-1:0]);
        phi_next = PP_W'(diff_reg) * PP_W'(inv_width_reg[INV_W-1:INV_HALF_W]);
    end

    //--------------------------------------------------------------------
    // stage 3: x = round(diff * inv), clamped to one
    //--------------------------------------------------------------------
    always_comb
    begin
        lo_rnd = XR_W'(plo_reg) + XR_W'(HALF);
        x_raw  = XR_W'(phi_reg) + (lo_rnd >> FRAC_BITS);
        x_next = (x_raw > XR_W'(ONE)) ? ONE : x_raw[VAL_W-1:0];
    end

    //--------------------------------------------------------------------
    // stage 4: x*x and 3 - 2x
    //--------------------------------------------------------------------
    always_comb
    begin
        sq_next = SQ_W'(x_reg) * SQ_W'(x_reg);
        k_next  = THREE_ONE - {x_reg, 1'b0};
    end

    //--------------------------------------------------------------------
    // stage 5: round the square
    //--------------------------------------------------------------------
    always_comb
    begin
        sq_rnd  = sq_reg + SQ_W'(HALF);
        x2_next = sq_rnd[FRAC_BITS +: VAL_W];
        k2_next = k_reg;
    end

    //--------------------------------------------------------------------
    // stage 6: x2 * (3 - 2x)
    //--------------------------------------------------------------------
    always_comb
    begin
        prod_next = PROD_W'(x2_reg) * PROD_W'(k2_reg);
    end

    //--------------------------------------------------------------------
    // stage 7: round, clamp, split weights (output register)
    //--------------------------------------------------------------------
    always_comb
    begin
        w_rnd   = prod_reg + PROD_W'(HALF);
        w_sh    = w_rnd[PROD_W-1:FRAC_BITS];
        w_val   = (w_sh > (PROD_W-FRAC_BITS)'(ONE)) ? ONE : w_sh[VAL_W-1:0];
        rw_next = blend_reg[6] ? w_val : ONE;
        pw_next = blend_reg[6] ? (ONE - w_val) : '0;
    end

    //--------------------------------------------------------------------
    // payload registers
    //--------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv[0])
            idx_reg[0] <= idx_next;
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (adv[k])
                idx_reg[k] <= idx_reg[k-1];
        end
        if (adv[1])
            blend_reg[1] <= blend_next;
        for (int k = 2; k < NUM_STAGES; k++)
        begin
            if (adv[k])
                blend_reg[k] <= blend_reg[k-1];
        end
        if (adv[0])
            pos_reg <= pos_next;
        if (adv[1])
            diff_reg <= diff_next;
        if (adv[2])
        begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
        if (adv[3])
            x_reg <= x_next;
        if (adv[4])
        begin
            sq_reg <= sq_next;
            k_reg  <= k_next;
        end
        if (adv[5])
        begin
            x2_reg <= x2_next;
            k2_reg <= k2_next;
        end
        if (adv[6])
            prod_reg <= prod_next;
        if (adv[7])
        begin
            rw_reg <= rw_next;
            pw_reg <= pw_next;
        end
    end

    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tuser  = blend_reg[NUM_STAGES-1];
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, pw_reg, rw_reg, idx_reg[NUM_STAGES-1]};

endmodule

// File: hw/rtl/rbss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbss_checker
// Port-level checks for the region band smoothstep weight engine.
// ----------------------------------------------------------------------------
module rbss_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [rbss_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              m_tuser
);
    import rbss_pkg::*;

    val_t region_weight;
    val_t previous_weight;
    idx_t region_index;

    assign region_index    = m_tdata[OUT_IDX_LSB +: IDX_W];
    assign region_weight   = m_tdata[OUT_RW_LSB +: VAL_W];
    assign previous_weight = m_tdata[OUT_PW_LSB +: VAL_W];

    // a held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // empty output stage means the pipeline can take a request
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // hard assignment gives full weight to the found region
    a_hard_weights: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> region_weight == ONE && previous_weight == '0)
        else $error("hard result weights wrong");

    // blended weights sum to one and never blend in region zero
    a_blend_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |->
            ({1'b0, region_weight} + {1'b0, previous_weight}) == {1'b0, ONE} &&
            region_index != '0)
        else $error("blend weights inconsistent");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> region_index <= IDX_W'(MAX_REGIONS - 1))
        else $error("region index out of range");

endmodule

bind region_band_smoothstep_weights rbss_checker u_rbss_checker (.*);
